// ----- hw/rtl/iir4_pkg.sv -----
package iir4_pkg;

  // Field widths and fixed-point formats
  localparam int SAMPLE_BITS    = 12;
  localparam int COEF_FRAC_BITS = 28;
  localparam int COEF_W         = 32;
  localparam int OUT_W          = 32;
  localparam int OUT_FRAC_BITS  = 16;
  localparam int HIST_DEPTH     = 4;
  localparam int NUM_TAPS       = HIST_DEPTH + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Accumulator widths: feed-forward sum of five products, feedback sum of four
  localparam int FF_W  = COEF_W + SAMPLE_BITS + 1 + 3;
  localparam int FB_W  = 2 * COEF_W + 2;
  localparam int ACC_W = ((FF_W + OUT_FRAC_BITS > FB_W) ? (FF_W + OUT_FRAC_BITS) : FB_W) + 1;
  localparam int SH_W  = ACC_W - COEF_FRAC_BITS;

  typedef logic signed [COEF_W-1:0] coef_word_t;
  typedef logic [SAMPLE_BITS-1:0]   sample_t;
  typedef logic signed [OUT_W-1:0]  out_word_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_COEF_01 = 3'd0,
    REG_NUM_COEF_23 = 3'd1,
    REG_NUM_COEF_4  = 3'd2,
    REG_DEN_COEF_12 = 3'd3,
    REG_DEN_COEF_34 = 3'd4
  } cfg_reg_t;

  // Coefficient set handed from the register bank to the datapath
  typedef struct packed {
    coef_word_t [NUM_TAPS-1:0] b;
    coef_word_t [HIST_DEPTH:1] a;
  } coef_set_t;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS =
    ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam out_word_t OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam out_word_t OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// ----- hw/rtl/iir4_cfg.sv -----
module iir4_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [iir4_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iir4_pkg::CFG_DATA_W-1:0]    cfg_data,
  output iir4_pkg::coef_set_t                coefs
);

  logic [2*iir4_pkg::COEF_W-1:0] num_coef_01_r;
  logic [2*iir4_pkg::COEF_W-1:0] num_coef_23_r;
  logic [iir4_pkg::COEF_W-1:0]   num_coef_4_r;
  logic [2*iir4_pkg::COEF_W-1:0] den_coef_12_r;
  logic [2*iir4_pkg::COEF_W-1:0] den_coef_34_r;

  assign cfg_ready = 1'b1;

  // Store a register write; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_coef_01_r <= '0;
      num_coef_23_r <= '0;
      num_coef_4_r  <= '0;
      den_coef_12_r <= '0;
      den_coef_34_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (iir4_pkg::cfg_reg_t'(cfg_index))
        iir4_pkg::REG_NUM_COEF_01: num_coef_01_r <= cfg_data[2*iir4_pkg::COEF_W-1:0];
        iir4_pkg::REG_NUM_COEF_23: num_coef_23_r <= cfg_data[2*iir4_pkg::COEF_W-1:0];
        iir4_pkg::REG_NUM_COEF_4:  num_coef_4_r  <= cfg_data[iir4_pkg::COEF_W-1:0];
        iir4_pkg::REG_DEN_COEF_12: den_coef_12_r <= cfg_data[2*iir4_pkg::COEF_W-1:0];
        iir4_pkg::REG_DEN_COEF_34: den_coef_34_r <= cfg_data[2*iir4_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack coefficient pairs
  always_comb begin
    coefs.b[0] = num_coef_01_r[iir4_pkg::COEF_W-1:0];
    coefs.b[1] = num_coef_01_r[2*iir4_pkg::COEF_W-1:iir4_pkg::COEF_W];
    coefs.b[2] = num_coef_23_r[iir4_pkg::COEF_W-1:0];
    coefs.b[3] = num_coef_23_r[2*iir4_pkg::COEF_W-1:iir4_pkg::COEF_W];
    coefs.b[4] = num_coef_4_r;
    coefs.a[1] = den_coef_12_r[iir4_pkg::COEF_W-1:0];
    coefs.a[2] = den_coef_12_r[2*iir4_pkg::COEF_W-1:iir4_pkg::COEF_W];
    coefs.a[3] = den_coef_34_r[iir4_pkg::COEF_W-1:0];
    coefs.a[4] = den_coef_34_r[2*iir4_pkg::COEF_W-1:iir4_pkg::COEF_W];
  end

endmodule

// ----- hw/rtl/iir4_mac.sv -----
module iir4_mac (
  input  iir4_pkg::coef_set_t                               coefs,
  input  iir4_pkg::sample_t                                 x_cur,
  input  iir4_pkg::sample_t [iir4_pkg::HIST_DEPTH-1:0]      x_hist,
  input  iir4_pkg::out_word_t [iir4_pkg::HIST_DEPTH-1:0]    y_hist,
  output iir4_pkg::out_word_t                               y_out
);

  iir4_pkg::sample_t                   taps    [iir4_pkg::NUM_TAPS];
  logic signed [iir4_pkg::FF_W-1:0]    ff_prod [iir4_pkg::NUM_TAPS];
  logic signed [2*iir4_pkg::COEF_W-1:0] fb_prod [iir4_pkg::HIST_DEPTH];
  logic signed [iir4_pkg::FF_W-1:0]    ff_sum;
  logic signed [iir4_pkg::FB_W-1:0]    fb_sum;
  logic signed [iir4_pkg::ACC_W-1:0]   acc;
  logic [iir4_pkg::SH_W-1:0]           acc_sh;
  logic [iir4_pkg::SH_W-iir4_pkg::OUT_W:0] acc_top;

  // Form all products in parallel
  always_comb begin
    taps[0] = x_cur;
    for (int k = 1; k < iir4_pkg::NUM_TAPS; k++) begin
      taps[k] = x_hist[k-1];
    end
    for (int k = 0; k < iir4_pkg::NUM_TAPS; k++) begin
      ff_prod[k] = iir4_pkg::FF_W'($signed(coefs.b[k])) *
                   iir4_pkg::FF_W'($signed({1'b0, taps[k]}));
    end
    for (int k = 0; k < iir4_pkg::HIST_DEPTH; k++) begin
      fb_prod[k] = (2*iir4_pkg::COEF_W)'($signed(coefs.a[k+1])) *
                   (2*iir4_pkg::COEF_W)'($signed(y_hist[k]));
    end
  end

  // Sum feed-forward and feedback terms, align and add rounding bias
  always_comb begin
    ff_sum = ff_prod[0] + ff_prod[1] + ff_prod[2] + ff_prod[3] + ff_prod[4];
    fb_sum = iir4_pkg::FB_W'(fb_prod[0]) + iir4_pkg::FB_W'(fb_prod[1]) +
             iir4_pkg::FB_W'(fb_prod[2]) + iir4_pkg::FB_W'(fb_prod[3]);
    acc    = (iir4_pkg::ACC_W'(ff_sum) <<< iir4_pkg::OUT_FRAC_BITS) -
             iir4_pkg::ACC_W'(fb_sum) + iir4_pkg::ROUND_BIAS;
  end

  // Drop coefficient fraction bits and saturate to the output width
  always_comb begin
    acc_sh  = acc[iir4_pkg::ACC_W-1:iir4_pkg::COEF_FRAC_BITS];
    acc_top = acc_sh[iir4_pkg::SH_W-1:iir4_pkg::OUT_W-1];
    if ((&acc_top) || !(|acc_top)) begin
      y_out = acc_sh[iir4_pkg::OUT_W-1:0];
    end else if (acc_sh[iir4_pkg::SH_W-1]) begin
      y_out = iir4_pkg::OUT_MIN;
    end else begin
      y_out = iir4_pkg::OUT_MAX;
    end
  end

endmodule

// ----- hw/rtl/fourth_order_iir_filter_top.sv -----
// Fourth-order direct-form-I IIR filter. Each request carries one unsigned 12-bit
// converter sample; the block returns one signed value with 16 fraction bits,
// computed as b0..b4 times the current and last four samples minus a1..a4 times
// the last four outputs, rounded to nearest (halves upwards) and saturated to 32
// bits. Coefficients are signed Q4.28, written two per register (b4 alone) over
// the cfg port; the user must write them only while the filter is idle, which
// the block does not enforce. They reset to zero, so the output is zero until
// they are loaded. It takes one sample per clock while out_ready holds high; a
// sample passes the sample register, then the result register. The clock rate
// is set by the feedback path: nine parallel 32-bit multiplies, the wide sum,
// rounding and saturation between the sample register and the output history.
module fourth_order_iir_filter_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [iir4_pkg::SAMPLE_BITS-1:0] in_raw_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [iir4_pkg::OUT_W-1:0] out_filtered_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [iir4_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [iir4_pkg::CFG_DATA_W-1:0]  cfg_data
);

  iir4_pkg::coef_set_t                              coefs;
  logic                                             smp_valid_r;
  iir4_pkg::sample_t                                smp_r;
  logic                                             out_valid_r;
  iir4_pkg::out_word_t                              out_r;
  iir4_pkg::sample_t [iir4_pkg::HIST_DEPTH-1:0]     x_hist_r;
  iir4_pkg::out_word_t [iir4_pkg::HIST_DEPTH-1:0]   y_hist_r;
  iir4_pkg::out_word_t                              y_mac;
  logic                                             advance;

  iir4_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  iir4_mac u_mac (
    .coefs  (coefs),
    .x_cur  (smp_r),
    .x_hist (x_hist_r),
    .y_hist (y_hist_r),
    .y_out  (y_mac)
  );

  // Advance the held sample once the result register is free or being drained
  assign advance  = smp_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !smp_valid_r || advance;

  // Control and history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      x_hist_r    <= '0;
      y_hist_r    <= '0;
    end else begin
      if (in_ready) begin
        smp_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        x_hist_r <= {x_hist_r[iir4_pkg::HIST_DEPTH-2:0], smp_r};
        y_hist_r <= {y_hist_r[iir4_pkg::HIST_DEPTH-2:0], y_mac};
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r <= in_raw_sample;
    end
    if (advance) begin
      out_r <= y_mac;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_r;

  // An empty sample register always takes a request
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !smp_valid_r |-> in_ready)
    else $error("sample register empty but request refused");

  // Each advanced sample enters the input history
  a_x_hist: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> x_hist_r[0] == $past(smp_r))
    else $error("input history missed a sample");

  // The result shown is the one written to the output history
  a_y_hist: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid && (out_filtered_value == y_hist_r[0]))
    else $error("result and output history disagree");

  // A pending result is not overwritten while stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !advance)
    else $error("result overwritten before it was taken");

endmodule
